// ===== sv/afi_pkg.sv =====
// shared types and constants for the 2d affine inverse pipeline
package afi_pkg;

   localparam int NUM_LANES = 6;

   localparam int LANE_A = 0;
   localparam int LANE_B = 1;
   localparam int LANE_C = 2;
   localparam int LANE_D = 3;
   localparam int LANE_E = 4;
   localparam int LANE_F = 5;

   typedef struct packed {
      logic valid;
      logic singular;
   } afi_ctl_type;

endpackage

// ===== sv/afi_if.sv =====
// matrix request and inverse response channel interfaces
interface afi_req_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] in_a;
   logic signed [WORD_BITS-1:0] in_b;
   logic signed [WORD_BITS-1:0] in_c;
   logic signed [WORD_BITS-1:0] in_d;
   logic signed [WORD_BITS-1:0] in_e;
   logic signed [WORD_BITS-1:0] in_f;

   modport source (output valid, in_a, in_b, in_c, in_d, in_e, in_f, input ready);
   modport sink   (input valid, in_a, in_b, in_c, in_d, in_e, in_f, output ready);
endinterface

interface afi_rsp_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] inv_a;
   logic signed [WORD_BITS-1:0] inv_b;
   logic signed [WORD_BITS-1:0] inv_c;
   logic signed [WORD_BITS-1:0] inv_d;
   logic signed [WORD_BITS-1:0] inv_e;
   logic signed [WORD_BITS-1:0] inv_f;
   logic                        singular;

   modport source (output valid, inv_a, inv_b, inv_c, inv_d, inv_e, inv_f, singular,
                   input ready);
   modport sink   (input valid, inv_a, inv_b, inv_c, inv_d, inv_e, inv_f, singular,
                   output ready);
endinterface

// ===== sv/afi_front.sv =====
// products, determinant and numerators in sign-magnitude form, two stages
module afi_front #(
   parameter int WORD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [WORD_BITS-1:0]   a,
   input  logic [WORD_BITS-1:0]   b,
   input  logic [WORD_BITS-1:0]   c,
   input  logic [WORD_BITS-1:0]   d,
   input  logic [WORD_BITS-1:0]   e,
   input  logic [WORD_BITS-1:0]   f,
   output logic [2*WORD_BITS:0]   det_mag,
   output logic [2*WORD_BITS:0]   num_mag [afi_pkg::NUM_LANES],
   output logic                   num_neg [afi_pkg::NUM_LANES],
   output logic                   singular
);

   localparam int W  = WORD_BITS;
   localparam int PW = 2 * W;
   localparam int NW = 2 * W + 1;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
      return x[W-1] ? (~x + W'(1)) : x;
   endfunction

   function automatic logic [NW:0] sm_add(input logic nx, input logic [PW-1:0] mx,
                                          input logic ny, input logic [PW-1:0] my);
      logic [NW-1:0] m;
      logic          n;
      if (nx == ny) begin
         m = NW'(mx) + NW'(my);
         n = nx;
      end else if (mx >= my) begin
         m = NW'(mx - my);
         n = nx;
      end else begin
         m = NW'(my - mx);
         n = ny;
      end
      if (m == '0) begin
         n = 1'b0;
      end
      return {n, m};
   endfunction

   // stage 1
   logic [W-1:0]  ma_ff, mb_ff, md_ff, me_ff;
   logic          na_ff, nb_ff, nd_ff, ne_ff;
   logic [PW-1:0] pae_ff, pbd_ff, pbf_ff, pce_ff, pcd_ff, paf_ff;
   logic          nae_ff, nbd_ff, nbf_ff, nce_ff, ncd_ff, naf_ff;
   logic          a_zero_ff;

   logic [W-1:0]  ma_in, mb_in, mc_in, md_in, me_in, mf_in;

   always_comb begin
      ma_in = mag_of(a);
      mb_in = mag_of(b);
      mc_in = mag_of(c);
      md_in = mag_of(d);
      me_in = mag_of(e);
      mf_in = mag_of(f);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff     <= ma_in;
         mb_ff     <= mb_in;
         md_ff     <= md_in;
         me_ff     <= me_in;
         na_ff     <= a[W-1];
         nb_ff     <= b[W-1];
         nd_ff     <= d[W-1];
         ne_ff     <= e[W-1];
         pae_ff    <= PW'(ma_in) * PW'(me_in);
         pbd_ff    <= PW'(mb_in) * PW'(md_in);
         pbf_ff    <= PW'(mb_in) * PW'(mf_in);
         pce_ff    <= PW'(mc_in) * PW'(me_in);
         pcd_ff    <= PW'(mc_in) * PW'(md_in);
         paf_ff    <= PW'(ma_in) * PW'(mf_in);
         nae_ff    <= a[W-1] ^ e[W-1];
         nbd_ff    <= b[W-1] ^ d[W-1];
         nbf_ff    <= b[W-1] ^ f[W-1];
         nce_ff    <= c[W-1] ^ e[W-1];
         ncd_ff    <= c[W-1] ^ d[W-1];
         naf_ff    <= a[W-1] ^ f[W-1];
         a_zero_ff <= (a == '0);
      end
   end

   // stage 2
   logic [NW:0] det_in, numc_in, numf_in;

   always_comb begin
      det_in  = sm_add(nae_ff, pae_ff, ~nbd_ff, pbd_ff);
      numc_in = sm_add(nbf_ff, pbf_ff, ~nce_ff, pce_ff);
      numf_in = sm_add(ncd_ff, pcd_ff, ~naf_ff, paf_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_mag                  <= det_in[NW-1:0];
         singular                 <= a_zero_ff || (det_in[NW-1:0] == '0);
         num_mag[afi_pkg::LANE_A] <= NW'(me_ff);
         num_neg[afi_pkg::LANE_A] <= ne_ff ^ det_in[NW];
         num_mag[afi_pkg::LANE_B] <= NW'(mb_ff);
         num_neg[afi_pkg::LANE_B] <= ~nb_ff ^ det_in[NW];
         num_mag[afi_pkg::LANE_C] <= numc_in[NW-1:0];
         num_neg[afi_pkg::LANE_C] <= numc_in[NW] ^ det_in[NW];
         num_mag[afi_pkg::LANE_D] <= NW'(md_ff);
         num_neg[afi_pkg::LANE_D] <= ~nd_ff ^ det_in[NW];
         num_mag[afi_pkg::LANE_E] <= NW'(ma_ff);
         num_neg[afi_pkg::LANE_E] <= na_ff ^ det_in[NW];
         num_mag[afi_pkg::LANE_F] <= numf_in[NW-1:0];
         num_neg[afi_pkg::LANE_F] <= numf_in[NW] ^ det_in[NW];
      end
   end

endmodule

// ===== sv/afi_div_lane.sv =====
// pipelined restoring divider, one quotient bit per stage, rounding and saturation
module afi_div_lane #(
   parameter int WORD_BITS = 32,
   parameter int SHIFT     = 32
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [2*WORD_BITS:0] num_mag,
   input  logic                 num_neg,
   input  logic [2*WORD_BITS:0] den_mag,
   output logic [WORD_BITS-1:0] quot
);

   localparam int W     = WORD_BITS;
   localparam int NW    = 2 * W + 1;
   localparam int DW    = 2 * W + 1;
   localparam int QW    = W + 1;
   localparam int DVW   = NW + SHIFT;
   localparam int HW    = DVW - QW;
   localparam int CW    = (HW > DW) ? HW : DW;
   localparam int STEPS = W + 1;

   logic [DW-1:0] rem_ff [STEPS+1];
   logic [QW-1:0] q_ff   [STEPS+1];
   logic [QW-1:0] low_ff [STEPS+1];
   logic [DW-1:0] den_ff [STEPS+1];
   logic          neg_ff [STEPS+1];
   logic          sat_ff [STEPS+1];

   // prep: overflow check on the high part
   logic [DVW-1:0] dvd_in;
   logic [CW-1:0]  high_in, den_ext_in;
   logic           sat_in;

   always_comb begin
      dvd_in     = DVW'(num_mag) << SHIFT;
      high_in    = CW'(dvd_in[DVW-1:QW]);
      den_ext_in = CW'(den_mag);
      sat_in     = (high_in >= den_ext_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= sat_in ? '0 : high_in[DW-1:0];
         q_ff[0]   <= '0;
         low_ff[0] <= dvd_in[QW-1:0];
         den_ff[0] <= den_mag;
         neg_ff[0] <= num_neg;
         sat_ff[0] <= sat_in;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [DW:0]   trial_in;
      logic          ge_in;
      logic [DW-1:0] rem_in;

      always_comb begin
         trial_in = {rem_ff[k], low_ff[k][W-k]};
         ge_in    = (trial_in >= {1'b0, den_ff[k]});
         rem_in   = ge_in ? DW'(trial_in - {1'b0, den_ff[k]}) : trial_in[DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            q_ff[k+1]   <= {q_ff[k][QW-2:0], ge_in};
            low_ff[k+1] <= low_ff[k];
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            sat_ff[k+1] <= sat_ff[k];
         end
      end
   end

   // round half away from zero on the magnitude
   logic [QW:0] qr_ff;
   logic        rneg_ff, rsat_ff;
   logic        rnd_in;

   always_comb begin
      rnd_in = ({rem_ff[STEPS], 1'b0} >= {1'b0, den_ff[STEPS]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qr_ff   <= {1'b0, q_ff[STEPS]} + (QW+1)'(rnd_in);
         rneg_ff <= neg_ff[STEPS];
         rsat_ff <= sat_ff[STEPS];
      end
   end

   // saturate and return to two's complement
   logic [QW:0]  limit_in, mag_in;
   logic         neg_in;
   logic [W-1:0] quot_in;

   always_comb begin
      limit_in = rneg_ff ? ((QW+1)'(1) << (W-1)) : (((QW+1)'(1) << (W-1)) - (QW+1)'(1));
      mag_in   = (rsat_ff || (qr_ff > limit_in)) ? limit_in : qr_ff;
      neg_in   = rneg_ff && (rsat_ff || (qr_ff != '0));
      quot_in  = neg_in ? (~mag_in[W-1:0] + W'(1)) : mag_in[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot <= quot_in;
      end
   end

endmodule

// ===== sv/affine_2d_inverse.sv =====
// top level of the pipelined 2d affine matrix inverter
// usage:
//   req_if carries one matrix [a b c; d e f] per transfer, all six fields
//   signed with FRAC_BITS fraction bits; rsp_if returns the inverse in the
//   same form plus a singular flag. singular is set, with all six fields
//   zero, when a or the determinant is zero; other results are rounded to
//   nearest (half away from zero) and saturated to the word range.
// pipeline: two stages form products, determinant and numerators, then each
//   of six divider lanes takes one stage to check overflow, one stage per
//   quotient bit (WORD_BITS + 1 of them), one to round and one to saturate.
// throughput: one matrix per cycle unless the pipeline holds for rsp_if.ready;
//   the quotient-bit stages of the six divider lanes set the depth, not the rate.
// stalls: while a response waits on rsp_if.ready the whole pipeline holds
//   and req_if.ready is low; nothing is dropped or repeated.
// reset: synchronous, clears every stage valid bit, so no response is
//   shown until new requests arrive.
module affine_2d_inverse #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   afi_req_if.sink   req_if,
   afi_rsp_if.source rsp_if
);

   localparam int W     = WORD_BITS;
   localparam int NW    = 2 * W + 1;
   localparam int DEPTH = W + 6;

   logic en;

   afi_pkg::afi_ctl_type ctl_ff [DEPTH];

   logic [NW-1:0] det_mag;
   logic [NW-1:0] num_mag [afi_pkg::NUM_LANES];
   logic          num_neg [afi_pkg::NUM_LANES];
   logic          fe_singular;
   logic [W-1:0]  quot [afi_pkg::NUM_LANES];

   assign en           = !ctl_ff[DEPTH-1].valid || rsp_if.ready;
   assign req_if.ready = en;

   afi_front #(
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .clock    (clock),
      .en       (en),
      .a        (req_if.in_a),
      .b        (req_if.in_b),
      .c        (req_if.in_c),
      .d        (req_if.in_d),
      .e        (req_if.in_e),
      .f        (req_if.in_f),
      .det_mag  (det_mag),
      .num_mag  (num_mag),
      .num_neg  (num_neg),
      .singular (fe_singular)
   );

   for (genvar i = 0; i < afi_pkg::NUM_LANES; i++) begin : g_lane
      localparam int LSHIFT =
         (i == afi_pkg::LANE_C || i == afi_pkg::LANE_F) ? FRAC_BITS : 2 * FRAC_BITS;

      afi_div_lane #(
         .WORD_BITS (WORD_BITS),
         .SHIFT     (LSHIFT)
      ) u_lane (
         .clock   (clock),
         .en      (en),
         .num_mag (num_mag[i]),
         .num_neg (num_neg[i]),
         .den_mag (det_mag),
         .quot    (quot[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            ctl_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         ctl_ff[0].valid <= req_if.valid;
         for (int k = 1; k < DEPTH; k++) begin
            ctl_ff[k].valid <= ctl_ff[k-1].valid;
         end
      end
      if (en) begin
         ctl_ff[0].singular <= 1'b0;
         ctl_ff[1].singular <= 1'b0;
         ctl_ff[2].singular <= fe_singular;
         for (int k = 3; k < DEPTH; k++) begin
            ctl_ff[k].singular <= ctl_ff[k-1].singular;
         end
      end
   end

   assign rsp_if.valid    = ctl_ff[DEPTH-1].valid;
   assign rsp_if.singular = ctl_ff[DEPTH-1].singular;
   assign rsp_if.inv_a    = ctl_ff[DEPTH-1].singular ? '0 : quot[afi_pkg::LANE_A];
   assign rsp_if.inv_b    = ctl_ff[DEPTH-1].singular ? '0 : quot[afi_pkg::LANE_B];
   assign rsp_if.inv_c    = ctl_ff[DEPTH-1].singular ? '0 : quot[afi_pkg::LANE_C];
   assign rsp_if.inv_d    = ctl_ff[DEPTH-1].singular ? '0 : quot[afi_pkg::LANE_D];
   assign rsp_if.inv_e    = ctl_ff[DEPTH-1].singular ? '0 : quot[afi_pkg::LANE_E];
   assign rsp_if.inv_f    = ctl_ff[DEPTH-1].singular ? '0 : quot[afi_pkg::LANE_F];

   a_stall_only_on_wait: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (rsp_if.valid && !rsp_if.ready))
      else $error("pipeline stalled without a waiting response");

   a_reset_empties: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_if.valid)
      else $error("response valid right after reset");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.singular) |->
         (rsp_if.inv_a == '0 && rsp_if.inv_e == '0 && rsp_if.inv_c == '0))
      else $error("singular response with nonzero coefficients");

endmodule

// ===== tb/affine_2d_inverse_test.sv =====
// self-checking testbench for the pipelined 2d affine matrix inverter
module affine_2d_inverse_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int NUM_RANDOM = 1900;
   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] MAXV = 32'h7fff_ffff;
   localparam logic [31:0] MINV = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] a, b, c, d, e, f;
   } matrix_t;

   typedef struct packed {
      logic [31:0] a, b, c, d, e, f;
      logic        singular;
   } inverse_t;

   typedef struct packed {
      matrix_t  m;
      logic     known;
      inverse_t inv;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count = 0;
   bit   sending_done = 1'b0;
   int   accepted = 0;
   inverse_t expected_inverses[$];

   afi_req_if #(.WORD_BITS(WORD_BITS)) req_if ();
   afi_rsp_if #(.WORD_BITS(WORD_BITS)) rsp_if ();

   affine_2d_inverse #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round(num * 2^sh / den), half away from zero, saturated
   function automatic logic [31:0] rounded_quotient(logic signed [127:0] num,
                                                    logic signed [127:0] den, int sh);
      logic [127:0] nm, dm, q, r, lim;
      logic         neg;
      nm = (num < 0) ? -num : num;
      dm = (den < 0) ? -den : den;
      nm = nm << sh;
      q = nm / dm;
      r = nm % dm;
      if ((r << 1) >= dm) q = q + 1;
      neg = ((num < 0) != (den < 0)) && (q != 0);
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > lim) q = lim;
      return neg ? (32'h0 - q[31:0]) : q[31:0];
   endfunction

   function automatic inverse_t invert_matrix(matrix_t m);
      logic signed [127:0] a, b, c, d, e, f, det;
      inverse_t            r;
      a = $signed(m.a); b = $signed(m.b); c = $signed(m.c);
      d = $signed(m.d); e = $signed(m.e); f = $signed(m.f);
      det = a * e - b * d;
      r = '0;
      if (a == 0 || det == 0) begin
         r.singular = 1'b1;
         return r;
      end
      r.a = rounded_quotient(e, det, 2 * FRAC_BITS);
      r.b = rounded_quotient(-b, det, 2 * FRAC_BITS);
      r.c = rounded_quotient(b * f - c * e, det, FRAC_BITS);
      r.d = rounded_quotient(-d, det, 2 * FRAC_BITS);
      r.e = rounded_quotient(a, det, 2 * FRAC_BITS);
      r.f = rounded_quotient(c * d - a * f, det, FRAC_BITS);
      return r;
   endfunction

   function automatic logic [31:0] random_coef(int kind);
      case (kind)
         0: return $urandom;
         1: return $signed($urandom_range(0, 16 * ONE)) - $signed(8 * ONE);
         2: return $signed($urandom_range(0, 64)) - 32;
         default: return $signed($urandom_range(0, 2 * ONE)) - $signed(ONE);
      endcase
   endfunction

   function automatic matrix_t random_matrix();
      matrix_t m;
      int      pick;
      pick = $urandom_range(0, 99);
      m.a = random_coef($urandom_range(0, 3));
      m.b = random_coef($urandom_range(0, 3));
      m.c = random_coef($urandom_range(0, 3));
      m.d = random_coef($urandom_range(0, 3));
      m.e = random_coef($urandom_range(0, 3));
      m.f = random_coef($urandom_range(0, 3));
      if (pick < 4) begin
         m.a = '0;
      end else if (pick < 8) begin
         m.d = m.a;
         m.e = m.b;
      end
      return m;
   endfunction

   function automatic int gap_cycles();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_matrix(matrix_t m, logic known, inverse_t inv);
      int gap;
      req_if.valid <= 1'b1;
      req_if.in_a <= m.a; req_if.in_b <= m.b; req_if.in_c <= m.c;
      req_if.in_d <= m.d; req_if.in_e <= m.e; req_if.in_f <= m.f;
      do @(posedge clock); while (!req_if.ready);
      expected_inverses.push_back(known ? inv : invert_matrix(m));
      accepted++;
      gap = gap_cycles();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      stim_row_t rows[14];
      inverse_t  none;
      matrix_t   m;
      none = '0;
      rows = '{
         '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
           '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1}},
         '{'{ONE, 32'h0, 32'h0, 32'h0, ONE, 32'h0}, 1'b1,
           '{ONE, 32'h0, 32'h0, 32'h0, ONE, 32'h0, 1'b0}},
         '{'{32'h0, ONE, 32'h5, ONE, ONE, 32'h7}, 1'b1,
           '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1}},
         '{'{ONE, ONE, 32'h3, ONE, ONE, 32'h9}, 1'b1,
           '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1}},
         '{'{32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0}, 1'b1,
           '{MAXV, 32'h0, 32'h0, 32'h0, MAXV, 32'h0, 1'b0}},
         '{'{32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 32'h0}, 1'b1,
           '{MINV, 32'h0, 32'h0, 32'h0, MINV, 32'h0, 1'b0}},
         '{'{MAXV, MAXV, MAXV, MAXV, MINV, MAXV}, 1'b0, none},
         '{'{MINV, MINV, MINV, MINV, MAXV, MINV}, 1'b0, none},
         '{'{MINV, 32'h0, MINV, 32'h0, MINV, MINV}, 1'b0, none},
         '{'{ONE, 32'h0, MAXV, 32'h0, ONE, MINV}, 1'b0, none},
         '{'{2 * ONE, ONE, 3 * ONE, ONE, 2 * ONE, 32'hfffe_0000}, 1'b0, none},
         '{'{3 * ONE, 32'h0, 32'h1, 32'h0, 32'h3, 32'h1}, 1'b0, none},
         '{'{32'h3, 32'h1, MAXV, 32'h1, 32'h2, MINV}, 1'b0, none},
         '{'{32'hffff_0000, 32'h8000, 32'h1_8000, 32'hffff_8000, ONE, 32'h1}, 1'b0, none}
      };
      req_if.valid = 1'b0;
      req_if.in_a = '0; req_if.in_b = '0; req_if.in_c = '0;
      req_if.in_d = '0; req_if.in_e = '0; req_if.in_f = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send_matrix(rows[i].m, rows[i].known, rows[i].inv);
      repeat (NUM_RANDOM) begin
         m = random_matrix();
         send_matrix(m, 1'b0, none);
      end
      req_if.valid <= 1'b0;
      sending_done = 1'b1;
   end

   // receiver stalls, with one long hold-off while the pipeline fills
   initial begin
      bit held;
      int gap;
      held = 1'b0;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (!held && accepted >= 400) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         gap = ($urandom_range(0, 3) == 0) ? gap_cycles() : 0;
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      inverse_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_inverses.size() == 0) begin
            $error("unexpected transfer on the response channel");
            fail_count++;
         end else begin
            want = expected_inverses.pop_front();
            if (rsp_if.inv_a !== want.a) begin
               $error("inv_a expected %h got %h", want.a, rsp_if.inv_a); fail_count++;
            end
            if (rsp_if.inv_b !== want.b) begin
               $error("inv_b expected %h got %h", want.b, rsp_if.inv_b); fail_count++;
            end
            if (rsp_if.inv_c !== want.c) begin
               $error("inv_c expected %h got %h", want.c, rsp_if.inv_c); fail_count++;
            end
            if (rsp_if.inv_d !== want.d) begin
               $error("inv_d expected %h got %h", want.d, rsp_if.inv_d); fail_count++;
            end
            if (rsp_if.inv_e !== want.e) begin
               $error("inv_e expected %h got %h", want.e, rsp_if.inv_e); fail_count++;
            end
            if (rsp_if.inv_f !== want.f) begin
               $error("inv_f expected %h got %h", want.f, rsp_if.inv_f); fail_count++;
            end
            if (rsp_if.singular !== want.singular) begin
               $error("singular expected %b got %b", want.singular, rsp_if.singular);
               fail_count++;
            end
         end
      end
   end

   initial begin
      wait (sending_done);
      wait (expected_inverses.size() == 0);
      repeat (WORD_BITS + 30) @(posedge clock);
      if (expected_inverses.size() != 0) begin
         $error("%0d inverses never arrived", expected_inverses.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
